/* hw/rtl/sfla_pkg.sv */
// shared types, codes and constants of the slot free-list allocator
package sfla_pkg;

    localparam int DEF_SLOTS = 256;

    localparam int OP_W     = 2;
    localparam int IDX_W    = 8;
    localparam int HANDLE_W = 32;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_LOOKUP = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_NOT_IN_USE = 2'd2
    } status_t;

    typedef struct packed {
        logic push;
        logic pop;
    } fl_cmd_t;

endpackage

/* hw/rtl/sfla_ram.sv */
// generic single-write, single-read ram with registered read data
module sfla_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
)(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/sfla_free_list.sv */
// free list: lifo stack of freed slots in ram over the untouched slots in reset order
module sfla_free_list
    import sfla_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS
)(
    input  logic                       clk,
    input  logic                       rst_n,
    input  fl_cmd_t                    cmd,
    input  logic [$clog2(SLOTS)-1:0]   push_slot,
    output logic [$clog2(SLOTS)-1:0]   head_slot,
    output logic                       avail,
    output logic [$clog2(SLOTS+1)-1:0] fresh_cnt
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    logic [CW-1:0] sp_reg, sp_next;
    logic [CW-1:0] fresh_reg, fresh_next;
    logic [AW-1:0] top_reg, top_next;
    logic          byp_reg;
    logic [AW-1:0] byp_data_reg;
    logic [AW-1:0] ram_q;
    logic [AW-1:0] below;
    logic [AW-1:0] fresh_slot;
    logic          stack_empty;
    logic          wr_en;
    logic          rd_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    sfla_ram #(
        .WIDTH (AW),
        .DEPTH (SLOTS)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (top_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    // untouched slots leave in the order 0, n-1, n-2, ... 1
    assign fresh_slot  = (fresh_reg == '0) ? '0 : AW'(CW'(SLOTS) - fresh_reg);
    assign stack_empty = (sp_reg == '0);
    assign head_slot   = stack_empty ? fresh_slot : top_reg;
    assign avail       = !stack_empty || (fresh_reg != CW'(SLOTS));
    assign fresh_cnt   = fresh_reg;
    assign below       = byp_reg ? byp_data_reg : ram_q;

    always_comb
    begin
        sp_next    = sp_reg;
        top_next   = top_reg;
        fresh_next = fresh_reg;
        wr_en      = 1'b0;
        rd_en      = cmd.push | cmd.pop;
        if (cmd.push)
        begin
            sp_next  = sp_reg + CW'(1);
            top_next = push_slot;
            wr_en    = !stack_empty;
        end
        else if (cmd.pop)
        begin
            if (!stack_empty)
            begin
                sp_next  = sp_reg - CW'(1);
                top_next = below;
            end
            else
            begin
                fresh_next = fresh_reg + CW'(1);
            end
        end
        wr_addr = AW'(sp_reg - CW'(1));
        // prefetch the entry under the new top
        rd_addr = AW'(sp_next - CW'(2));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg    <= '0;
            fresh_reg <= '0;
            byp_reg   <= 1'b0;
        end
        else
        begin
            sp_reg    <= sp_next;
            fresh_reg <= fresh_next;
            if (rd_en)
            begin
                byp_reg <= wr_en;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (rd_en && wr_en)
        begin
            byp_data_reg <= top_reg;
        end
    end

endmodule

/* hw/rtl/sfla_slot_table.sv */
// handle table in ram with write-to-read bypass
module sfla_slot_table
    import sfla_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [$clog2(SLOTS)-1:0] rd_addr,
    input  logic                     wr_en,
    input  logic [$clog2(SLOTS)-1:0] wr_addr,
    input  logic [HANDLE_W-1:0]      wr_data,
    output logic [HANDLE_W-1:0]      rd_handle
);

    logic                byp_reg;
    logic                byp_next;
    logic [HANDLE_W-1:0] byp_data_reg;
    logic [HANDLE_W-1:0] ram_q;

    sfla_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (SLOTS)
    ) u_handle_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    assign byp_next  = wr_en && (wr_addr == rd_addr);
    assign rd_handle = byp_reg ? byp_data_reg : ram_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            byp_reg <= byp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en && byp_next)
        begin
            byp_data_reg <= wr_data;
        end
    end

endmodule

/* hw/rtl/slot_free_list_allocator_core.sv */
// Slot allocator over a pool of SLOTS slots with a LIFO free list. One word is
// taken every cycle while in_stall is low, and each word gives one result word
// through the input register (slot table read at the input edge) and the result
// register. Allocate pops the free-list head, free pushes a slot in use, look up
// returns a slot's handle. Reset takes effect at once with no clearing pass:
// a fill count of slots ever handed out marks which table entries hold data.
module slot_free_list_allocator_core
    import sfla_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [OP_W-1:0]     opcode,
    input  logic [IDX_W-1:0]    slot_index,
    input  logic [HANDLE_W-1:0] handle,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [IDX_W-1:0]    granted_index,
    output logic [HANDLE_W-1:0] slot_handle
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    logic                s1_valid_reg;
    logic [OP_W-1:0]     s1_op_reg;
    logic [IDX_W-1:0]    s1_idx_reg;
    logic [HANDLE_W-1:0] s1_handle_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [IDX_W-1:0]    granted_reg;
    logic [HANDLE_W-1:0] shown_reg;

    status_t             status_next;
    logic [IDX_W-1:0]    granted_next;
    logic [HANDLE_W-1:0] shown_next;

    logic                in_accept;
    logic                fire;

    fl_cmd_t             fl_cmd;
    logic [AW-1:0]       head_slot;
    logic                fl_avail;
    logic [CW-1:0]       fresh_cnt;

    logic                tbl_wr_en;
    logic [AW-1:0]       tbl_wr_addr;
    logic [HANDLE_W-1:0] tbl_wr_data;
    logic [HANDLE_W-1:0] tbl_handle;

    logic                idx_in_range;
    logic [AW-1:0]       idx_addr;
    logic [CW-1:0]       idx_pos;
    logic                idx_written;
    logic [HANDLE_W-1:0] stored;
    logic                in_use;

    assign fire      = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !fire;
    assign in_accept = in_valid && !in_stall;

    sfla_free_list #(
        .SLOTS (SLOTS)
    ) u_free_list (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (fl_cmd),
        .push_slot (idx_addr),
        .head_slot (head_slot),
        .avail     (fl_avail),
        .fresh_cnt (fresh_cnt)
    );

    sfla_slot_table #(
        .SLOTS (SLOTS)
    ) u_slot_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_accept),
        .rd_addr   (AW'(slot_index)),
        .wr_en     (tbl_wr_en),
        .wr_addr   (tbl_wr_addr),
        .wr_data   (tbl_wr_data),
        .rd_handle (tbl_handle)
    );

    always_comb
    begin
        idx_in_range = (32'(s1_idx_reg) < 32'(SLOTS));
        idx_addr     = AW'(s1_idx_reg);
        idx_pos      = CW'(SLOTS) - CW'(s1_idx_reg);
        // a slot holds data only once it has left the untouched region
        idx_written  = (s1_idx_reg == '0) ? (fresh_cnt != '0) : (idx_pos < fresh_cnt);
        stored       = idx_written ? tbl_handle : '0;
        in_use       = idx_in_range && (stored != '0);

        fl_cmd       = '0;
        tbl_wr_en    = 1'b0;
        tbl_wr_addr  = idx_addr;
        tbl_wr_data  = '0;
        status_next  = ST_OK;
        granted_next = '0;
        shown_next   = '0;

        unique case (s1_op_reg)
            OP_ALLOC:
            begin
                if (fl_avail && (s1_handle_reg != '0))
                begin
                    fl_cmd.pop   = fire;
                    tbl_wr_en    = fire;
                    tbl_wr_addr  = head_slot;
                    tbl_wr_data  = s1_handle_reg;
                    granted_next = IDX_W'(head_slot);
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            OP_FREE:
            begin
                if (in_use)
                begin
                    fl_cmd.push = fire;
                    tbl_wr_en   = fire;
                end
                else
                begin
                    status_next = ST_NOT_IN_USE;
                end
            end
            OP_LOOKUP:
            begin
                shown_next = idx_in_range ? stored : '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg     <= opcode;
            s1_idx_reg    <= slot_index;
            s1_handle_reg <= handle;
        end
        if (fire)
        begin
            status_reg  <= status_next;
            granted_reg <= granted_next;
            shown_reg   <= shown_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign granted_index = granted_reg;
    assign slot_handle   = shown_reg;

endmodule

/* tb/slot_free_list_allocator_core_test.sv */
// self-checking testbench of the slot free-list allocator core
`timescale 1ns / 100ps

module slot_free_list_allocator_core_test;
    import sfla_pkg::*;

    localparam int SLOTS      = DEF_SLOTS;
    localparam int LINK_W     = $clog2(SLOTS) + 1;
    localparam int QUIET_MAX  = 2000;
    localparam int PHASE_LEN  = 260;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        status_t               status;
        logic [IDX_W-1:0]      granted;
        logic [HANDLE_W-1:0]   shown;
    } reply_t;

    class alloc_scoreboard;
        logic [LINK_W-1:0]   head;
        logic [LINK_W-1:0]   link [SLOTS];
        logic [HANDLE_W-1:0] held [SLOTS];
        reply_t              replies_due [$];
        int                  errors;
        int                  busy;

        function new();
            head   = '0;
            errors = 0;
            busy   = 0;
            for (int k = 0; k < SLOTS; k++)
            begin
                held[k] = '0;
                link[k] = (k >= 2) ? LINK_W'(k - 1) : LINK_W'(SLOTS);
            end
            link[0] = LINK_W'(SLOTS - 1);
        endfunction

        function bit pool_full();
            return head >= SLOTS;
        endfunction

        function bit in_use(int idx);
            return idx < SLOTS && held[idx] != '0;
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        function void note_word(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                logic [HANDLE_W-1:0] h);
            reply_t r;
            int     s;
            r.status  = ST_OK;
            r.granted = '0;
            r.shown   = '0;
            case (op)
                OP_ALLOC:
                    if (head >= SLOTS || h == '0)
                        r.status = ST_FULL;
                    else
                    begin
                        s         = int'(head);
                        head      = link[s];
                        link[s]   = LINK_W'(SLOTS);
                        held[s]   = h;
                        r.granted = IDX_W'(s);
                        busy++;
                    end
                OP_FREE:
                    if (!in_use(int'(idx)))
                        r.status = ST_NOT_IN_USE;
                    else
                    begin
                        held[idx] = '0;
                        link[idx] = head;
                        head      = LINK_W'(idx);
                        busy--;
                    end
                OP_LOOKUP:
                    if (int'(idx) < SLOTS)
                        r.shown = held[idx];
                default:
                    ;
            endcase
            replies_due.push_back(r);
        endfunction

        function void check_reply(logic [STATUS_W-1:0] st, logic [IDX_W-1:0] gi,
                                  logic [HANDLE_W-1:0] sh);
            reply_t r;
            if (replies_due.size() == 0)
            begin
                $error("result word with nothing expected: status %0d index %0d handle %h",
                       st, gi, sh);
                errors++;
                return;
            end
            r = replies_due.pop_front();
            if (st !== r.status)
            begin
                $error("status: expected %0d, actual %0d", r.status, st);
                errors++;
            end
            if (gi !== r.granted)
            begin
                $error("granted_index: expected %0d, actual %0d", r.granted, gi);
                errors++;
            end
            if (sh !== r.shown)
            begin
                $error("slot_handle: expected %h, actual %h", r.shown, sh);
                errors++;
            end
        endfunction
    endclass

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                in_valid      = 1'b0;
    logic                in_stall;
    logic [OP_W-1:0]     opcode        = '0;
    logic [IDX_W-1:0]    slot_index    = '0;
    logic [HANDLE_W-1:0] handle        = '0;
    logic                out_valid;
    logic                out_stall     = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    granted_index;
    logic [HANDLE_W-1:0] slot_handle;

    alloc_scoreboard sb;
    int  in_idle_pct   = 0;
    int  out_stall_pct = 0;
    int  quiet         = 0;
    bit  filling       = 1'b1;
    int  full_tries    = 0;
    int  idle_plan  [4] = '{0, 65, 0, 35};
    int  stall_plan [4] = '{0, 0, 65, 35};

    slot_free_list_allocator_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .slot_index    (slot_index),
        .handle        (handle),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .granted_index (granted_index),
        .slot_handle   (slot_handle)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < out_stall_pct);

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_reply(status, granted_index, slot_handle);

    always @(posedge clk)
    begin
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_MAX)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                             input logic [HANDLE_W-1:0] h);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        slot_index <= idx;
        handle     <= h;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_word(op, idx, h);
    endtask

    function automatic logic [HANDLE_W-1:0] pick_handle();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return '0;
        if (r < 10)
            return '1;
        if (r < 13)
            return HANDLE_W'(1);
        return $urandom();
    endfunction

    function automatic logic [IDX_W-1:0] pick_busy_slot();
        int start;
        int k;
        start = $urandom_range(SLOTS - 1);
        for (int n = 0; n < SLOTS; n++)
        begin
            k = (start + n) % SLOTS;
            if (sb.in_use(k))
                return IDX_W'(k);
        end
        return IDX_W'(start);
    endfunction

    // fill the pool to overflow, then drain it, over and over
    task automatic random_word();
        int               r;
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] idx;
        r   = $urandom_range(99);
        idx = IDX_W'($urandom());
        if (r < (filling ? 75 : 15))
            op = OP_ALLOC;
        else if (r < (filling ? 88 : 80))
        begin
            op = OP_FREE;
            if ($urandom_range(99) < 75)
                idx = pick_busy_slot();
        end
        else if (r < 97)
        begin
            op = OP_LOOKUP;
            if ($urandom_range(1) == 1)
                idx = pick_busy_slot();
        end
        else
            op = OP_UNUSED;
        if (op == OP_ALLOC && sb.pool_full())
            full_tries++;
        send_word(op, idx, pick_handle());
        if (filling && full_tries >= 4)
            filling = 1'b0;
        else if (!filling && sb.busy < 8)
        begin
            filling    = 1'b1;
            full_tries = 0;
        end
    endtask

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_word(OP_LOOKUP, 8'd0,   32'hFFFF_FFFF);
        send_word(OP_FREE,   8'd0,   32'h1234_5678);
        send_word(OP_ALLOC,  8'hFF,  32'h0000_0000);
        send_word(OP_ALLOC,  8'd0,   32'hFFFF_FFFF);
        send_word(OP_ALLOC,  8'hAA,  32'h0000_0001);
        send_word(OP_ALLOC,  8'h55,  32'h8000_0000);
        send_word(OP_LOOKUP, 8'd0,   32'h0000_0000);
        send_word(OP_LOOKUP, 8'hFF,  32'hFFFF_FFFF);
        send_word(OP_LOOKUP, 8'hFE,  32'h0000_0000);
        send_word(OP_UNUSED, 8'hFF,  32'hFFFF_FFFF);
        send_word(OP_FREE,   8'hFF,  32'h0000_0000);
        send_word(OP_FREE,   8'hFF,  32'hFFFF_FFFF);
        send_word(OP_ALLOC,  8'd0,   32'h5555_5555);
        send_word(OP_FREE,   8'd0,   32'h0000_0000);
        send_word(OP_FREE,   8'hFE,  32'h0000_0000);
        send_word(OP_LOOKUP, 8'd0,   32'hAAAA_AAAA);
        send_word(OP_ALLOC,  8'hFF,  32'hAAAA_AAAA);
        send_word(OP_ALLOC,  8'd0,   32'h0000_FFFF);
        send_word(OP_LOOKUP, 8'hFE,  32'h5A5A_A5A5);
        send_word(OP_LOOKUP, 8'd0,   32'h0000_0000);
        send_word(OP_UNUSED, 8'd0,   32'h0000_0000);

        for (int p = 0; p < 4; p++)
        begin
            in_idle_pct   = idle_plan[p];
            out_stall_pct = stall_plan[p];
            repeat (PHASE_LEN) random_word();
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
